### hdl/mi_pkg.sv
// Package for the modular inverse pipeline: widths, the prime, the fixed exponent,
// the Barrett constant and the control struct. No dependencies.
package mi_pkg;

    localparam int VAL_W    = 31;
    localparam int RES_W    = 30;
    localparam int EXP_BITS = 30;
    localparam int MUL_LAT  = 5;
    localparam int TOTAL    = EXP_BITS * MUL_LAT;

    localparam logic [RES_W-1:0] PRIME    = 30'd1000000007;
    localparam logic [VAL_W-1:0] PRIME_X1 = 31'd1000000007;
    localparam logic [VAL_W-1:0] PRIME_X2 = 31'd2000000014;
    localparam logic [31:0]      PRIME_32 = 32'd1000000007;
    localparam logic [31:0]      PRIME2_32 = 32'd2000000014;
    // Exponent is the prime minus two.
    localparam logic [EXP_BITS-1:0] EXPONENT = 30'd1000000005;
    // Barrett factor: floor(2^60 / prime).
    localparam logic [30:0] MU = 31'd1152921496;

    typedef struct packed {
        logic valid;
        logic exists;
    } t_ctrl;

endpackage

### hdl/mi_if.sv
// Handshake interfaces for the input and result channels.
// Depends on nothing.
interface mi_in_if;
    logic        valid;
    logic        ready;
    logic [30:0] value_in;
    modport source (output valid, output value_in, input ready);
    modport sink   (input valid, input value_in, output ready);
endinterface

interface mi_out_if;
    logic        valid;
    logic        ready;
    logic        inverse_exists;
    logic [29:0] inverse_value;
    modport source (output valid, output inverse_exists, output inverse_value, input ready);
    modport sink   (input valid, input inverse_exists, input inverse_value, output ready);
endinterface

### hdl/modular_inverse_fermat.sv
// Modular inverse modulo 1000000007 as value^(prime-2), fully pipelined.
// Results leave through an output register; throughput one transaction per cycle while the skid register is empty.
// Each of the 30 exponent bits is one square-and-multiply step built from 5-stage multipliers.
// Reset (synchronous, active low) clears the valid and control bits only; datapath registers are not reset.
// Depends on mi_pkg, mi_if, mi_mulmod and mi_delay.
module modular_inverse_fermat
    import mi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    mi_in_if.sink       i_in,
    mi_out_if.source    o_out
);

    // Output register with a one-entry skid register behind it.
    logic             r_out_valid;
    logic             r_out_exists;
    logic [RES_W-1:0] r_out_value;
    logic             r_skid_valid;
    logic             r_skid_exists;
    logic [RES_W-1:0] r_skid_value;
    logic [RES_W-1:0] n_value;

    // The whole pipeline advances together. It halts only when the skid
    // register is occupied, so a result waiting at the output does not by
    // itself stop new transactions from entering.
    logic w_en;
    assign w_en = !r_skid_valid;
    assign i_in.ready = w_en;

    // Input stage: the 31-bit value is below three times the prime, so a
    // single subtraction of the prime or of twice the prime brings it into range.
    logic [VAL_W-1:0] n_red;
    always_comb begin
        if (i_in.value_in >= PRIME_X2) begin
            n_red = i_in.value_in - PRIME_X2;
        end else if (i_in.value_in >= PRIME_X1) begin
            n_red = i_in.value_in - PRIME_X1;
        end else begin
            n_red = i_in.value_in;
        end
    end

    t_ctrl            r_ctl [0:TOTAL];
    logic [RES_W-1:0] r_base;
    logic [RES_W-1:0] w_acc [0:EXP_BITS];
    logic [RES_W-1:0] w_sq  [0:EXP_BITS-1];

    // Control bits follow the data through every stage of the chain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= TOTAL; k++) begin
                r_ctl[k] <= '0;
            end
        end else if (w_en) begin
            r_ctl[0].valid  <= i_in.valid;
            r_ctl[0].exists <= (n_red != '0);
            for (int k = 1; k <= TOTAL; k++) begin
                r_ctl[k] <= r_ctl[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_base <= n_red[RES_W-1:0];
        end
    end

    assign w_acc[0] = {{(RES_W-1){1'b0}}, 1'b1};
    assign w_sq[0]  = r_base;

    // One step per exponent bit, least significant first: the squaring runs
    // for every bit but the last, whose square is never needed, and the
    // accumulator is multiplied in only where the bit is set; otherwise it
    // is delayed to stay aligned.
    genvar i;
    generate
        for (i = 0; i < EXP_BITS; i++) begin : g_step
            if (i < EXP_BITS - 1) begin : g_sq
                mi_mulmod u_sq (
                    .i_clk (i_clk),
                    .i_en  (w_en),
                    .i_a   (w_sq[i]),
                    .i_b   (w_sq[i]),
                    .o_y   (w_sq[i+1])
                );
            end
            if (EXPONENT[i]) begin : g_mul
                mi_mulmod u_acc (
                    .i_clk (i_clk),
                    .i_en  (w_en),
                    .i_a   (w_acc[i]),
                    .i_b   (w_sq[i]),
                    .o_y   (w_acc[i+1])
                );
            end else begin : g_pass
                mi_delay u_acc (
                    .i_clk (i_clk),
                    .i_en  (w_en),
                    .i_d   (w_acc[i]),
                    .o_q   (w_acc[i+1])
                );
            end
        end
    endgenerate

    assign n_value = r_ctl[TOTAL].exists ? w_acc[EXP_BITS] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || o_out.ready) begin
            if (r_skid_valid) begin
                r_out_valid   <= 1'b1;
                r_out_exists  <= r_skid_exists;
                r_out_value   <= r_skid_value;
                r_skid_valid  <= 1'b0;
            end else begin
                r_out_valid   <= r_ctl[TOTAL].valid;
                r_out_exists  <= r_ctl[TOTAL].exists;
                r_out_value   <= n_value;
            end
        end else if (w_en && r_ctl[TOTAL].valid) begin
            r_skid_valid  <= 1'b1;
            r_skid_exists <= r_ctl[TOTAL].exists;
            r_skid_value  <= n_value;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.inverse_exists = r_out_exists;
    assign o_out.inverse_value  = r_out_value;

endmodule

### hdl/mi_mulmod.sv
// Five-stage pipelined multiplier modulo the prime, Barrett reduction.
// Depends on mi_pkg.
module mi_mulmod
    import mi_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [RES_W-1:0] i_a,
    input  logic [RES_W-1:0] i_b,
    output logic [RES_W-1:0] o_y
);

    logic [59:0]      r_prod;
    logic [61:0]      r_qm;
    logic [31:0]      r_x2;
    logic [31:0]      r_t;
    logic [31:0]      r_x3;
    logic [31:0]      r_rem;
    logic [RES_W-1:0] r_y;
    logic [61:0]      n_qp;
    logic [31:0]      n_fix;

    always_comb begin
        n_qp = {31'd0, r_qm[61:31]} * {32'd0, PRIME};
        if (r_rem >= PRIME2_32) begin
            n_fix = r_rem - PRIME2_32;
        end else if (r_rem >= PRIME_32) begin
            n_fix = r_rem - PRIME_32;
        end else begin
            n_fix = r_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= {30'd0, i_a} * {30'd0, i_b};
            r_qm   <= {31'd0, r_prod[59:29]} * {31'd0, MU};
            r_x2   <= r_prod[31:0];
            r_t    <= n_qp[31:0];
            r_x3   <= r_x2;
            r_rem  <= r_x3 - r_t;
            r_y    <= n_fix[RES_W-1:0];
        end
    end

    assign o_y = r_y;

endmodule

### hdl/mi_delay.sv
// Delay line matching the multiplier latency, for steps whose exponent bit is clear.
// Depends on mi_pkg.
module mi_delay
    import mi_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [RES_W-1:0] i_d,
    output logic [RES_W-1:0] o_q
);

    logic [RES_W-1:0] r_tap [0:MUL_LAT-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_d;
            for (int k = 1; k < MUL_LAT; k++) begin
                r_tap[k] <= r_tap[k-1];
            end
        end
    end

    assign o_q = r_tap[MUL_LAT-1];

endmodule

### tb/tb_modular_inverse_fermat.sv
// Testbench for modular_inverse_fermat: directed table then random values, with a
// square-and-multiply predictor. Depends on mi_pkg, mi_if and the block itself.
module tb_modular_inverse_fermat
    import mi_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // One row of the directed table. When has_expect is set the expected result
    // is typed in and is compared with the predictor as well.
    typedef struct {
        logic [VAL_W-1:0] value;
        bit               has_expect;
        logic             exists;
        logic [RES_W-1:0] inverse;
    } t_row;

    typedef struct packed {
        logic             exists;
        logic [RES_W-1:0] inverse;
    } t_result;

    localparam int N_RANDOM = 1130;

    logic i_clk;
    logic i_rst_n;

    mi_in_if  in_ch();
    mi_out_if out_ch();

    modular_inverse_fermat uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_result inverse_queue[$];
    int      mismatch_count;
    bit      stim_done;
    t_row    directed[$];

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Inverse by square-and-multiply, using 64-bit products reduced modulo the prime.
    function automatic t_result predict_inverse(logic [VAL_W-1:0] value);
        logic [63:0] residue;
        logic [63:0] acc;
        logic [63:0] sq;
        logic [63:0] expo;
        t_result     res;
        residue = 64'(value) % 64'(PRIME_32);
        if (residue == 64'd0) begin
            res.exists  = 1'b0;
            res.inverse = '0;
        end else begin
            acc  = 64'd1;
            sq   = residue;
            expo = 64'(PRIME_32) - 64'd2;
            while (expo != 64'd0) begin
                if (expo[0]) begin
                    acc = (acc * sq) % 64'(PRIME_32);
                end
                sq   = (sq * sq) % 64'(PRIME_32);
                expo = expo >> 1;
            end
            res.exists  = 1'b1;
            res.inverse = acc[RES_W-1:0];
        end
        return res;
    endfunction

    // Each accepted input transaction queues its expected result.
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            inverse_queue.push_back(predict_inverse(in_ch.value_in));
        end
    end

    // Each accepted output transaction is compared with the oldest expectation.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (inverse_queue.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("Unexpected result: exists=%0d inverse=%0d",
                             out_ch.inverse_exists, out_ch.inverse_value);
                end
            end else begin
                want = inverse_queue.pop_front();
                if (out_ch.inverse_exists !== want.exists
                    || out_ch.inverse_value !== want.inverse) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display({"Mismatch: expected exists=%0d inverse=%0d,",
                                  " got exists=%0d inverse=%0d"},
                                 want.exists, want.inverse,
                                 out_ch.inverse_exists, out_ch.inverse_value);
                    end
                end
            end
        end
    end

    // The receiver stalls at random, drawing each cycle either a calm or a choppy stall probability.
    always @(posedge i_clk) begin
        int phase;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b1;
        end else begin
            phase = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) < 3) begin
                out_ch.ready <= 1'b1;
            end else if (phase) begin
                out_ch.ready <= ($urandom_range(0, 2) != 0);
            end else begin
                out_ch.ready <= ($urandom_range(0, 9) != 0);
            end
        end
    end

    function automatic logic [VAL_W-1:0] random_value();
        int kind;
        kind = $urandom_range(0, 9);
        case (kind)
            0: return PRIME_X1 + VAL_W'($urandom_range(0, 3)) - VAL_W'(2);
            1: return PRIME_X2 + VAL_W'($urandom_range(0, 3)) - VAL_W'(2);
            2: return VAL_W'($urandom_range(0, 15));
            3: return {VAL_W{1'b1}} - VAL_W'($urandom_range(0, 15));
            default: return VAL_W'($urandom());
        endcase
    endfunction

    // Present one value and hold it until the block accepts the transaction.
    task automatic send_value(logic [VAL_W-1:0] value);
        in_ch.valid    <= 1'b1;
        in_ch.value_in <= value;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic idle_gap(int cycles);
        in_ch.valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    initial begin
        int burst;
        int sent;
        in_ch.valid    = 1'b0;
        in_ch.value_in = '0;
        i_rst_n        = 1'b0;
        mismatch_count = 0;
        stim_done      = 1'b0;

        // Zero, the multiples of the prime, their neighbours, the input extremes, bit patterns and small values.
        directed.push_back('{31'd0,              1'b1, 1'b0, 30'd0});
        directed.push_back('{PRIME_X1,           1'b1, 1'b0, 30'd0});
        directed.push_back('{PRIME_X2,           1'b1, 1'b0, 30'd0});
        directed.push_back('{31'd1,              1'b1, 1'b1, 30'd1});
        directed.push_back('{PRIME_X1 + 31'd1,   1'b1, 1'b1, 30'd1});
        directed.push_back('{PRIME_X2 + 31'd1,   1'b1, 1'b1, 30'd1});
        directed.push_back('{PRIME_X1 - 31'd1,   1'b1, 1'b1, 30'd1000000006});
        directed.push_back('{PRIME_X2 - 31'd1,   1'b1, 1'b1, 30'd1000000006});
        directed.push_back('{31'd2,              1'b1, 1'b1, 30'd500000004});
        directed.push_back('{31'h7FFF_FFFF,      1'b0, 1'b0, 30'd0});
        directed.push_back('{31'h4000_0000,      1'b0, 1'b0, 30'd0});
        directed.push_back('{31'h5555_5555,      1'b0, 1'b0, 30'd0});
        directed.push_back('{31'h2AAA_AAAA,      1'b0, 1'b0, 30'd0});
        directed.push_back('{31'd3,              1'b0, 1'b0, 30'd0});
        directed.push_back('{PRIME_X1 + 31'd2,   1'b0, 1'b0, 30'd0});
        directed.push_back('{31'd999999999,      1'b0, 1'b0, 30'd0});

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) begin
            // Typed-in rows double-check the predictor itself.
            if (directed[k].has_expect
                && predict_inverse(directed[k].value)
                   != {directed[k].exists, directed[k].inverse}) begin
                mismatch_count++;
                $display("Table row %0d disagrees with prediction", k);
            end
            send_value(directed[k].value);
        end

        // Hold off until the pipeline has drained completely.
        idle_gap(1);
        while (inverse_queue.size() != 0) begin
            @(posedge i_clk);
        end

        sent = 0;
        while (sent < N_RANDOM) begin
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst && sent < N_RANDOM; b++) begin
                send_value(random_value());
                sent++;
            end
            if ($urandom_range(0, 2) != 0) begin
                idle_gap($urandom_range(1, 12));
            end
        end
        in_ch.valid <= 1'b0;

        while (inverse_queue.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TOTAL + 20) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Safety net: far beyond the slowest correct run.
    initial begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule

### modular_inverse_fermat.f
hdl/mi_pkg.sv
hdl/mi_if.sv
hdl/mi_mulmod.sv
hdl/mi_delay.sv
hdl/modular_inverse_fermat.sv
tb/tb_modular_inverse_fermat.sv
